/* rtl/mand_pkg.sv */
// Shared types and constants of the Mandelbrot escape-time pixel engine.
package mand_pkg;

    // Fixed-point format and framebuffer layout.
    localparam int FRAC_BITS       = 27;
    localparam int BYTES_PER_PIXEL = 4;

    // Field and register widths.
    localparam int PIX_W   = 12;
    localparam int SIZE_W  = PIX_W + 1;
    localparam int STEP_W  = 31;
    localparam int CFG_W   = 32;
    localparam int CNT_W   = 16;
    localparam int LINE_W  = 15;
    localparam int OFF_W   = 27;
    localparam int COLOR_W = 24;
    localparam int IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PIXEL_STEP   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_RE    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CENTER_IM    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_MAX_ITER     = 3'd5;
    localparam logic [IDX_W-1:0] CFG_LINE_BYTES   = 3'd6;

    // Datapath widths derived from the fraction width.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int D_W    = PIX_W + 3;
    localparam int MAP_W  = 48;
    localparam int CW     = FRAC_BITS + 5;
    localparam int ZW     = FRAC_BITS + 3;
    localparam int NZW    = FRAC_BITS + 6;
    localparam int SQ_W   = 2 * ZW;

    localparam logic signed [MAP_W-1:0] C_LIM     = MAP_W'(8) <<< FRAC_BITS;
    localparam logic signed [MAP_W-1:0] C_LIM_NEG = -C_LIM;
    localparam logic signed [NZW-1:0]   Z_TWO     = NZW'(2) <<< FRAC_BITS;
    localparam logic signed [NZW-1:0]   Z_TWO_NEG = -Z_TWO;
    localparam logic signed [SQ_W-1:0]  Z_FOUR    = SQ_W'(4) <<< (2 * FRAC_BITS);

    // Colour gradient: count * 255 / max_iter, an 8-bit quotient.
    localparam int Q_W        = 8;
    localparam int DIVIDEND_W = CNT_W + Q_W;
    localparam int DSTEP_W    = $clog2(Q_W + 1);
    localparam int RED_LSB    = 16;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [CNT_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/mand_div.sv */
// Bit-serial restoring divider for the colour gradient quotient.
module mand_div
    import mand_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DSTEP_W-1:0] cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]     low_reg, low_next;
    logic [CNT_W-1:0]   divisor_reg, divisor_next;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] trial_diff;
    logic           trial_fits;

    // The quotient is known to stay below 2^Q_W, so the upper dividend bits
    // already form a remainder smaller than the divisor.
    assign trial      = {rem_reg, low_reg[Q_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_fits = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        low_next     = low_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            rem_next     = req.dividend[DIVIDEND_W-1:Q_W];
            low_next     = req.dividend[Q_W-1:0];
            divisor_next = req.divisor;
            cnt_next     = DSTEP_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = trial_fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            low_next  = {low_reg[Q_W-2:0], trial_fits};
            cnt_next  = cnt_reg - DSTEP_W'(1);
            done_next = (cnt_reg == DSTEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = low_reg;

endmodule

/* rtl/mandelbrot_escape_time_pixel.sv */
// Top level of the Mandelbrot escape-time pixel engine.
// A pixel outside the frame goes straight to the result step. One pixel at a time:
// the next beat can be taken once the result is offered, and a result still stalled
// on the output holds the next one back. An iteration steps through S_CROSS,
// S_UPDATE, S_SQ_RE and S_SQ_IM.
// Reset (rst_n, asynchronous, active low) idles the sequencer and loads register defaults.
module mandelbrot_escape_time_pixel
    import mand_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel_x,
    input  logic [PIX_W-1:0]   pixel_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COLOR_W-1:0] pixel_color,
    output logic [CNT_W-1:0]   iter_count,
    output logic               inside_set,
    output logic [OFF_W-1:0]   byte_offset,
    output logic               pixel_written
);

    // Sequencer codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAP_RE = 4'd1;
    localparam logic [3:0] S_MAP_IM = 4'd2;
    localparam logic [3:0] S_OFFSET = 4'd3;
    localparam logic [3:0] S_SETUP  = 4'd4;
    localparam logic [3:0] S_CROSS  = 4'd5;
    localparam logic [3:0] S_UPDATE = 4'd6;
    localparam logic [3:0] S_SQ_RE  = 4'd7;
    localparam logic [3:0] S_SQ_IM  = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;
    localparam logic [3:0] S_DIVIDE = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Configuration registers.
    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [STEP_W-1:0] pixel_step_reg;
    logic [CFG_W-1:0]  center_re_reg;
    logic [CFG_W-1:0]  center_im_reg;
    logic [CNT_W-1:0]  iter_limit_reg;
    logic [LINE_W-1:0] line_bytes_reg;

    // Control state.
    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Working registers.
    logic [PIX_W-1:0]         x_reg, x_next;
    logic [PIX_W-1:0]         y_reg, y_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [CW-1:0]     cr_reg, cr_next;
    logic signed [CW-1:0]     ci_reg, ci_next;
    logic signed [ZW-1:0]     zr_reg, zr_next;
    logic signed [ZW-1:0]     zi_reg, zi_next;
    logic signed [SQ_W-1:0]   rr_reg, rr_next;
    logic signed [SQ_W-1:0]   ii_reg, ii_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic                     first_reg, first_next;
    logic                     written_reg, written_next;
    logic                     inside_reg, inside_next;
    logic [OFF_W-1:0]         offset_reg, offset_next;
    logic [COLOR_W-1:0]       color_reg, color_next;

    // Output registers.
    logic [COLOR_W-1:0] pixel_color_reg, pixel_color_next;
    logic [CNT_W-1:0]   iter_count_reg, iter_count_next;
    logic               inside_set_reg, inside_set_next;
    logic [OFF_W-1:0]   byte_offset_reg, byte_offset_next;
    logic               pixel_written_reg, pixel_written_next;

    // Shared multiplier and the logic around it.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [D_W-1:0]    d_re, d_im;
    logic [CFG_W-1:0]         c_center;
    logic signed [PROD_W-1:0] prod_half;
    logic signed [MAP_W-1:0]  c_sum;
    logic signed [SQ_W-1:0]   sq_diff, sq_diff_sh, sq_sum;
    logic signed [PROD_W-1:0] cross_sh;
    logic signed [NZW-1:0]    zr_new, zi_new;
    logic                     box_escape;
    logic [CNT_W-1:0]         n_inc;
    logic                     outside;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Clamp a mapped coordinate to plus or minus eight.
    function automatic logic signed [CW-1:0] c_sat(input logic signed [MAP_W-1:0] v);
        logic signed [CW-1:0] r;
        if (v > C_LIM)
            r = C_LIM[CW-1:0];
        else if (v < C_LIM_NEG)
            r = C_LIM_NEG[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // Distance from the frame center in half pixels: 2*pixel - size.
    assign d_re = $signed({2'b00, x_reg, 1'b0}) - $signed({2'b00, frame_width_reg});
    assign d_im = $signed({2'b00, y_reg, 1'b0}) - $signed({2'b00, frame_height_reg});

    // One multiplier serves the coordinate mapping, the row offset and the
    // three products of every iteration, in that order of sequencer steps.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MAP_RE:
            begin
                mul_a = {{(MUL_W-D_W){d_re[D_W-1]}}, d_re};
                mul_b = {1'b0, pixel_step_reg};
            end
            S_MAP_IM:
            begin
                mul_a = {{(MUL_W-D_W){d_im[D_W-1]}}, d_im};
                mul_b = {1'b0, pixel_step_reg};
            end
            S_OFFSET:
            begin
                mul_a = {{(MUL_W-PIX_W){1'b0}}, y_reg};
                mul_b = {{(MUL_W-LINE_W){1'b0}}, line_bytes_reg};
            end
            S_CROSS:
            begin
                mul_a = {{(MUL_W-ZW){zr_reg[ZW-1]}}, zr_reg};
                mul_b = {{(MUL_W-ZW){zi_reg[ZW-1]}}, zi_reg};
            end
            S_SQ_RE:
            begin
                mul_a = {{(MUL_W-ZW){zr_reg[ZW-1]}}, zr_reg};
                mul_b = {{(MUL_W-ZW){zr_reg[ZW-1]}}, zr_reg};
            end
            S_SQ_IM:
            begin
                mul_a = {{(MUL_W-ZW){zi_reg[ZW-1]}}, zi_reg};
                mul_b = {{(MUL_W-ZW){zi_reg[ZW-1]}}, zi_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // The mapped product is halved with a floor shift and added to the center
    // of whichever axis was just multiplied.
    assign c_center  = (state_reg == S_MAP_IM) ? center_re_reg : center_im_reg;
    assign prod_half = prod_reg >>> 1;
    assign c_sum     = $signed(prod_half[MAP_W-1:0])
                     + $signed({{(MAP_W-CFG_W){c_center[CFG_W-1]}}, c_center});

    // z update: the squares come from the previous escape test, the cross
    // product from this iteration's first step; 2*zr*zi is a shift one less.
    assign sq_diff    = rr_reg - ii_reg;
    assign sq_diff_sh = sq_diff >>> FRAC_BITS;
    assign cross_sh   = prod_reg >>> (FRAC_BITS - 1);
    assign zr_new     = $signed(sq_diff_sh[NZW-1:0])
                      + $signed({{(NZW-CW){cr_reg[CW-1]}}, cr_reg});
    assign zi_new     = $signed(cross_sh[NZW-1:0])
                      + $signed({{(NZW-CW){ci_reg[CW-1]}}, ci_reg});
    assign box_escape = (zr_new > Z_TWO) || (zr_new < Z_TWO_NEG)
                     || (zi_new > Z_TWO) || (zi_new < Z_TWO_NEG);
    assign sq_sum     = rr_reg + ii_reg;
    assign n_inc      = n_reg + CNT_W'(1);

    assign outside = ({1'b0, pixel_x} >= frame_width_reg)
                  || ({1'b0, pixel_y} >= frame_height_reg);

    // The gradient dividend is count * 255, formed as (count << 8) - count.
    assign div_req.dividend = {n_reg, {Q_W{1'b0}}} - {{Q_W{1'b0}}, n_reg};
    assign div_req.divisor  = iter_limit_reg;
    assign div_req.start    = (state_reg == S_FINISH) && (n_reg != iter_limit_reg);

    mand_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next         = state_reg;
        out_valid_next     = out_valid_reg && out_stall;
        x_next             = x_reg;
        y_next             = y_reg;
        prod_next          = prod_reg;
        cr_next            = cr_reg;
        ci_next            = ci_reg;
        zr_next            = zr_reg;
        zi_next            = zi_reg;
        rr_next            = rr_reg;
        ii_next            = ii_reg;
        n_next             = n_reg;
        first_next         = first_reg;
        written_next       = written_reg;
        inside_next        = inside_reg;
        offset_next        = offset_reg;
        color_next         = color_reg;
        pixel_color_next   = pixel_color_reg;
        iter_count_next    = iter_count_reg;
        inside_set_next    = inside_set_reg;
        byte_offset_next   = byte_offset_reg;
        pixel_written_next = pixel_written_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next       = pixel_x;
                    y_next       = pixel_y;
                    written_next = !outside;
                    state_next   = outside ? S_DONE : S_MAP_RE;
                end
            end
            S_MAP_RE:
            begin
                prod_next  = mul_p;
                state_next = S_MAP_IM;
            end
            S_MAP_IM:
            begin
                cr_next    = c_sat(c_sum);
                prod_next  = mul_p;
                state_next = S_OFFSET;
            end
            S_OFFSET:
            begin
                ci_next    = c_sat(c_sum);
                prod_next  = mul_p;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                offset_next = prod_reg[OFF_W-1:0]
                            + OFF_W'(x_reg) * OFF_W'(BYTES_PER_PIXEL);
                zr_next     = '0;
                zi_next     = '0;
                rr_next     = '0;
                ii_next     = '0;
                n_next      = '0;
                first_next  = 1'b1;
                state_next  = (iter_limit_reg == '0) ? S_FINISH : S_CROSS;
            end
            S_CROSS:
            begin
                // Escape test of the previous update, then the cross product.
                first_next = 1'b0;
                if (!first_reg && (sq_sum > Z_FOUR))
                    state_next = S_FINISH;
                else if (!first_reg && (n_inc == iter_limit_reg))
                begin
                    n_next     = n_inc;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (!first_reg)
                        n_next = n_inc;
                    prod_next  = mul_p;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (box_escape)
                    state_next = S_FINISH;
                else
                begin
                    zr_next    = zr_new[ZW-1:0];
                    zi_next    = zi_new[ZW-1:0];
                    state_next = S_SQ_RE;
                end
            end
            S_SQ_RE:
            begin
                rr_next    = mul_p[SQ_W-1:0];
                state_next = S_SQ_IM;
            end
            S_SQ_IM:
            begin
                ii_next    = mul_p[SQ_W-1:0];
                state_next = S_CROSS;
            end
            S_FINISH:
            begin
                if (n_reg == iter_limit_reg)
                begin
                    inside_next = 1'b1;
                    color_next  = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    inside_next = 1'b0;
                    state_next  = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    color_next = COLOR_W'({div_rsp.quotient, {RED_LSB{1'b0}}});
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the output register once the previous beat has left.
                if (!out_valid_reg || !out_stall)
                begin
                    pixel_written_next = written_reg;
                    pixel_color_next   = written_reg ? color_reg : '0;
                    iter_count_next    = written_reg ? n_reg : '0;
                    inside_set_next    = written_reg && inside_reg;
                    byte_offset_next   = written_reg ? offset_reg : '0;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= SIZE_W'(800);
            frame_height_reg <= SIZE_W'(800);
            pixel_step_reg   <= STEP_W'(671089);
            center_re_reg    <= CFG_W'(-67108864);
            center_im_reg    <= '0;
            iter_limit_reg   <= CNT_W'(50);
            line_bytes_reg   <= LINE_W'(3200);
        end
        else if (cfg_write)
        begin
            // Writes to an index past the register list are dropped.
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_PIXEL_STEP:   pixel_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_CENTER_RE:    center_re_reg    <= cfg_data;
                CFG_CENTER_IM:    center_im_reg    <= cfg_data;
                CFG_MAX_ITER:     iter_limit_reg   <= cfg_data[CNT_W-1:0];
                CFG_LINE_BYTES:   line_bytes_reg   <= cfg_data[LINE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg             <= x_next;
        y_reg             <= y_next;
        prod_reg          <= prod_next;
        cr_reg            <= cr_next;
        ci_reg            <= ci_next;
        zr_reg            <= zr_next;
        zi_reg            <= zi_next;
        rr_reg            <= rr_next;
        ii_reg            <= ii_next;
        n_reg             <= n_next;
        first_reg         <= first_next;
        written_reg       <= written_next;
        inside_reg        <= inside_next;
        offset_reg        <= offset_next;
        color_reg         <= color_next;
        pixel_color_reg   <= pixel_color_next;
        iter_count_reg    <= iter_count_next;
        inside_set_reg    <= inside_set_next;
        byte_offset_reg   <= byte_offset_next;
        pixel_written_reg <= pixel_written_next;
    end

    // The engine takes a new beat only from the idle step.
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign pixel_color   = pixel_color_reg;
    assign iter_count    = iter_count_reg;
    assign inside_set    = inside_set_reg;
    assign byte_offset   = byte_offset_reg;
    assign pixel_written = pixel_written_reg;

    // A pixel inside the set is always drawn black.
    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inside_set && (pixel_color != '0)))
        else $error("inside pixel carries a nonzero colour");

    // A skipped pixel carries no count, flag or offset.
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_written)
        |-> ((iter_count == '0) && (byte_offset == '0) && !inside_set))
        else $error("skipped pixel carries result fields");

    // The count never runs past the limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_written) |-> (iter_count <= iter_limit_reg))
        else $error("iteration count exceeds the limit");

    // An accepted beat keeps the engine busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("engine ready right after accepting a beat");

endmodule

/* test/mandelbrot_escape_time_pixel_tb.sv */
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
module mandelbrot_escape_time_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mand_pkg::*;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

    // The plane span of 4.0 in Q5.27, used to size the step to the frame.
    localparam int unsigned PLANE_SPAN = 32'd1 << (FRAC_BITS + 2);

    // Center of -0.5 in Q5.27, the value the block comes out of reset with.
    localparam logic [CFG_W-1:0] CENTER_HALF_LEFT = 32'hFC00_0000;

    // One result beat, laid out in the order of the output ports.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   count;
        logic               in_set;
        logic [OFF_W-1:0]   offset;
        logic               written;
    } pixel_result_t;

    // Keeps its own copy of the registers, works out every accepted pixel
    // and holds the results in the order the block must deliver them.
    class escape_scoreboard;
        int unsigned   frame_w;
        int unsigned   frame_h;
        int unsigned   step;
        longint        center_re;
        longint        center_im;
        int unsigned   iter_limit;
        int unsigned   line_bytes;
        pixel_result_t pending_pixels[$];
        int            errors;

        function new();
            frame_w    = 800;
            frame_h    = 800;
            step       = 671089;
            center_re  = -67108864;
            center_im  = 0;
            iter_limit = 50;
            line_bytes = 3200;
            errors     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_FRAME_WIDTH:  frame_w    = 32'(data[SIZE_W-1:0]);
                CFG_FRAME_HEIGHT: frame_h    = 32'(data[SIZE_W-1:0]);
                CFG_PIXEL_STEP:   step       = 32'(data[STEP_W-1:0]);
                CFG_CENTER_RE:    center_re  = longint'($signed(data));
                CFG_CENTER_IM:    center_im  = longint'($signed(data));
                CFG_MAX_ITER:     iter_limit = 32'(data[CNT_W-1:0]);
                CFG_LINE_BYTES:   line_bytes = 32'(data[LINE_W-1:0]);
                default: ;
            endcase
        endfunction

        // Plane coordinate of a pixel: the half step comes from d = 2*pix - size,
        // the product is floored, and the sum is clamped to +-8.
        function longint map_to_plane(int unsigned pix, int unsigned size, longint center);
            longint d;
            longint c;
            longint lim;
            lim = longint'(8) <<< FRAC_BITS;
            d   = 2 * longint'(pix) - longint'(size);
            c   = center + ((d * longint'(step)) >>> 1);
            if (c > lim)
                c = lim;
            if (c < -lim)
                c = -lim;
            return c;
        endfunction

        // Counts the updates of z = z*z + c that stay inside the radius-2 disk.
        function int unsigned count_escape(longint cr, longint ci, int unsigned limit);
            longint      zr;
            longint      zi;
            longint      rr;
            longint      ii;
            longint      ri;
            longint      two;
            longint      four;
            int unsigned n;
            two  = longint'(2) <<< FRAC_BITS;
            four = longint'(4) <<< (2 * FRAC_BITS);
            zr   = 0;
            zi   = 0;
            n    = 0;
            while (n < limit) begin
                rr = zr * zr;
                ii = zi * zi;
                ri = 2 * zr * zi;
                zr = ((rr - ii) >>> FRAC_BITS) + cr;
                zi = (ri >>> FRAC_BITS) + ci;
                if (zr > two || zr < -two || zi > two || zi < -two)
                    break;
                if (zr * zr + zi * zi > four)
                    break;
                n++;
            end
            return n;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
            pixel_result_t r;
            int unsigned   n;
            r = '0;
            if (x < frame_w && y < frame_h) begin
                n = count_escape(map_to_plane(x, frame_w, center_re),
                                 map_to_plane(y, frame_h, center_im), iter_limit);
                r.count  = CNT_W'(n);
                r.in_set = (n == iter_limit);
                // Red gradient; a pixel inside the set is black, so a zero
                // limit never reaches the division.
                if (!r.in_set)
                    r.color = COLOR_W'((n * 255 / iter_limit) << RED_LSB);
                r.offset  = OFF_W'(longint'(y) * line_bytes + longint'(x) * BYTES_PER_PIXEL);
                r.written = 1'b1;
            end
            pending_pixels.push_back(r);
        endfunction

        function void check_pixel(pixel_result_t got);
            pixel_result_t want;
            if (pending_pixels.size() == 0) begin
                $error("result beat with no pixel pending");
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.color !== want.color) begin
                $error("pixel_color: expected %06h, got %06h", want.color, got.color);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("iter_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.in_set !== want.in_set) begin
                $error("inside_set: expected %0b, got %0b", want.in_set, got.in_set);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $error("byte_offset: expected %0h, got %0h", want.offset, got.offset);
                errors++;
            end
            if (got.written !== want.written) begin
                $error("pixel_written: expected %0b, got %0b", want.written, got.written);
                errors++;
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_write     = 1'b0;
    logic [IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]   cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [PIX_W-1:0]   pixel_x       = '0;
    logic [PIX_W-1:0]   pixel_y       = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [COLOR_W-1:0] pixel_color;
    logic [CNT_W-1:0]   iter_count;
    logic               inside_set;
    logic [OFF_W-1:0]   byte_offset;
    logic               pixel_written;
    pixel_result_t      dut_result;

    escape_scoreboard sb;

    // Percent of cycles in which the sender holds back a beat and in which
    // the receiver stalls.
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;

    mandelbrot_escape_time_pixel dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_color   (pixel_color),
        .iter_count    (iter_count),
        .inside_set    (inside_set),
        .byte_offset   (byte_offset),
        .pixel_written (pixel_written)
    );

    assign dut_result = {pixel_color, iter_count, inside_set, byte_offset, pixel_written};

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Result side. The outputs are read right after the edge, before the
    // block's own updates land, so they hold the values seen at the edge.
    // A beat moves when out_valid was high and our stall was low.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_pixel(dut_result);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Holds the pixel on the port until the block takes it, with random
    // gaps in front of it. Valid is raised or lowered once per edge at most.
    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= x;
        pixel_y  <= y;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(x, y);
    endtask

    // Stops sending and waits for every pixel in flight to come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_pixels.size() != 0);
    endtask

    // One register write; the enable drops for a cycle after each write.
    task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(index, data);
        @(posedge clk);
    endtask

    // Reprograms the whole view once the block has gone idle.
    task automatic program_view(int unsigned w, int unsigned h, int unsigned step,
                                logic [CFG_W-1:0] cre, logic [CFG_W-1:0] cim,
                                int unsigned iters, int unsigned line);
        wait_for_results();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_PIXEL_STEP, step);
        write_reg(CFG_CENTER_RE, cre);
        write_reg(CFG_CENTER_IM, cim);
        write_reg(CFG_MAX_ITER, iters);
        write_reg(CFG_LINE_BYTES, line);
    endtask

    // Mostly small frames so that most pixels land inside, now and then
    // the full 4096, and rarely a size of zero or one beyond the pixel range.
    function automatic int unsigned pick_size();
        case ($urandom_range(7))
            0, 1, 2: return $urandom_range(1, 64);
            3, 4, 5: return $urandom_range(1, 4096);
            6:       return 4096;
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    // A random view. The step usually spans the plane over the shorter side
    // with some zoom, so that escape counts spread out; the center usually
    // lies within +-2. The iteration limit stays small to keep the run short.
    task automatic random_view();
        int unsigned      w;
        int unsigned      h;
        int unsigned      span;
        int unsigned      step;
        int unsigned      iters;
        logic [CFG_W-1:0] cre;
        logic [CFG_W-1:0] cim;
        w    = pick_size();
        h    = pick_size();
        span = (w < h) ? w : h;
        if (span == 0)
            span = 1;
        step = PLANE_SPAN / span / $urandom_range(1, 16);
        case ($urandom_range(7))
            0:       step = $urandom & 32'h7FFF_FFFF;
            1:       step = 0;
            default: ;
        endcase
        if ($urandom_range(7) == 0) begin
            cre = $urandom;
            cim = $urandom;
        end
        else begin
            cre = $urandom_range(0, 1 << 29) - (1 << 28);
            cim = $urandom_range(0, 1 << 29) - (1 << 28);
        end
        case ($urandom_range(9))
            0:       iters = 0;
            1:       iters = $urandom_range(97, 300);
            default: iters = $urandom_range(1, 96);
        endcase
        program_view(w, h, step, cre, cim, iters, $urandom & 32'h7FFF);
    endtask

    // Most pixels fall inside the frame; the rest are drawn from the whole
    // coordinate range and mostly miss it.
    task automatic random_pixels(int count);
        int unsigned      xmax;
        int unsigned      ymax;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        xmax = (sb.frame_w > 4096) ? 4095 : sb.frame_w - 1;
        ymax = (sb.frame_h > 4096) ? 4095 : sb.frame_h - 1;
        repeat (count) begin
            if (sb.frame_w != 0 && sb.frame_h != 0 && $urandom_range(99) < 85) begin
                x = PIX_W'($urandom_range(0, xmax));
                y = PIX_W'($urandom_range(0, ymax));
            end
            else begin
                x = PIX_W'($urandom);
                y = PIX_W'($urandom);
            end
            send_pixel(x, y);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        sb        = new();
        send_idle = 27;
        recv_idle = 59;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset view: corners, the center (inside the set), the first
        // coordinates past the frame and the largest coordinates.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd799, 12'd799);
        send_pixel(12'd400, 12'd400);
        send_pixel(12'd200, 12'd400);
        send_pixel(12'd800, 12'd5);
        send_pixel(12'd5, 12'd800);
        send_pixel(12'd4095, 12'd4095);

        // A frame of zero size puts every pixel outside.
        program_view(0, 0, 671089, CENTER_HALF_LEFT, '0, 50, 3200);
        send_pixel(12'd0, 12'd0);

        // Zero step and zero limit: no iteration and no division.
        program_view(8191, 4096, 0, '0, '0, 0, 4);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);

        // Largest step and extreme centers: c clamps to +-8 and escapes at
        // once; the widest line gives the largest byte offsets.
        program_view(4096, 4096, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     65535, 32767);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);

        // The full iteration limit on the origin, which never escapes. The
        // write to the unused index must leave every register alone.
        program_view(64, 64, 1, '0, '0, 65535, 256);
        write_reg(CFG_UNUSED, 32'h0000_0001);
        send_pixel(12'd32, 12'd32);
        send_pixel(12'd64, 12'd0);
        send_pixel(12'd3, 12'd70);

        // Random views. The idle pattern swaps after three views, and the
        // last two run with both sides at full rate. Each reprogramming
        // first lets the block drain completely.
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 3) begin
                send_idle = 59;
                recv_idle = 27;
            end
            if (phase == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_view();
            random_pixels(50);
        end

        // Drain, then leave room for any stray beat to show up.
        wait_for_results();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial
    begin : watchdog
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* mandelbrot_escape_time_pixel.f */
rtl/mand_pkg.sv
rtl/mand_div.sv
rtl/mandelbrot_escape_time_pixel.sv
test/mandelbrot_escape_time_pixel_tb.sv
